>>> rtl/cbg_pkg.sv
// types and constants of the clocked burst generator
// stream payload layouts and configuration register indexes; no dependencies
`default_nettype none

package cbg_pkg;

  localparam int unsigned CHANCE_W   = 16;
  localparam int unsigned BURST_W    = 8;
  localparam int unsigned TICKS_W    = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // payload fields: 74 bits, padded to 80
  localparam int unsigned IN_FIELDS_W = 2 + BURST_W + 4 * CHANCE_W;
  localparam int unsigned IN_W        = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned OUT_FIELDS_W = 5;
  localparam int unsigned OUT_W        = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic [TICKS_W-1:0] PULSE_TICKS_RST = TICKS_W'(48);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RETRIGGER   = 2'd0,
    REG_BYPASS      = 2'd1,
    REG_PULSE_TICKS = 2'd2
  } cbg_reg_e;

  // packed structs list the msb first, so the last field comes first
  typedef struct packed {
    logic [IN_W-IN_FIELDS_W-1:0] pad;
    logic [CHANCE_W-1:0]         rand_pulse;
    logic [CHANCE_W-1:0]         rand_clock;
    logic [CHANCE_W-1:0]         pulse_chance;
    logic [CHANCE_W-1:0]         clock_chance;
    logic [BURST_W-1:0]          burst_length;
    logic                        trigger_level;
    logic                        clock_level;
  } cbg_in_t;

  typedef struct packed {
    logic [OUT_W-OUT_FIELDS_W-1:0] pad;
    logic                          clock_out;
    logic                          end_trigger;
    logic                          start_trigger;
    logic                          burst_gate;
    logic                          pulse_out;
  } cbg_out_t;

endpackage

`default_nettype wire

>>> rtl/clocked_burst_generator.sv
// clocked burst generator, one result per tick transaction; depends on cbg_pkg
// the result of each input transaction is registered in the output register
// throughput: one tick per cycle; the input stays ready while the output
// register is empty or being drained in the same cycle
// reset: asynchronous, no burst running, clock and pulse tests passed,
// trigger pulse length 48 ticks
`default_nettype none

module clocked_burst_generator #(
  parameter int unsigned MAX_BURST = 128
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // configuration write port
  input  wire logic                          cfg_we_i,
  input  wire logic [cbg_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [cbg_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  // input ticks
  input  wire logic                          s_axis_tvalid,
  output      logic                          s_axis_tready,
  // clock_level, trigger_level, burst_length, clock_chance, pulse_chance,
  // rand_clock, rand_pulse, zero pad
  input  wire logic [cbg_pkg::IN_W-1:0]      s_axis_tdata,
  // results
  output      logic                          m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // pulse_out, burst_gate, start_trigger, end_trigger, clock_out, zero pad
  output      logic [cbg_pkg::OUT_W-1:0]     m_axis_tdata
);
  import cbg_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_BURST + 1);
  localparam int unsigned CmpW = (CntW > BURST_W) ? CntW : BURST_W;

  // configuration
  logic               retrig_q;
  logic               bypass_q;
  logic [TICKS_W-1:0] pulse_ticks_q;

  // burst state; pulse count holds pulse_index + 1
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic               in_burst_q, in_burst_d;
  logic               start_pend_q, start_pend_d;
  logic               clk_pass_q, clk_pass_d;
  logic               pls_pass_q, pls_pass_d;
  logic               last_clk_q, last_trig_q;
  logic [TICKS_W-1:0] start_left_q, start_left_d;
  logic [TICKS_W-1:0] end_left_q, end_left_d;

  logic               out_valid_q, out_valid_d;
  cbg_out_t           out_q, out_d;

  cbg_in_t            tick;
  logic               accept;
  logic [CmpW-1:0]    pulses;
  logic [CmpW-1:0]    bl_ext;
  logic               trig_acc;
  logic               last_clk_eff;
  logic               rise, fall;
  logic               start_out, end_out;

  assign tick          = cbg_in_t'(s_axis_tdata);
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      retrig_q      <= 1'b0;
      bypass_q      <= 1'b0;
      pulse_ticks_q <= PULSE_TICKS_RST;
    end else if (cfg_we_i) begin
      unique case (cbg_reg_e'(cfg_idx_i))
        REG_RETRIGGER:   retrig_q      <= cfg_wdata_i[0];
        REG_BYPASS:      bypass_q      <= cfg_wdata_i[0];
        REG_PULSE_TICKS: pulse_ticks_q <= cfg_wdata_i[TICKS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    // burst length clamped to one..MAX_BURST
    bl_ext = CmpW'(tick.burst_length);
    if (bl_ext == '0) begin
      pulses = CmpW'(1);
    end else if (bl_ext > CmpW'(MAX_BURST)) begin
      pulses = CmpW'(MAX_BURST);
    end else begin
      pulses = bl_ext;
    end

    trig_acc     = tick.trigger_level && !last_trig_q && (!in_burst_q || retrig_q);
    // an accepted trigger lets a clock that is already high count as a rising edge
    last_clk_eff = trig_acc ? 1'b0 : last_clk_q;
    start_pend_d = trig_acc || start_pend_q;
    cnt_d        = trig_acc ? '0 : cnt_q;

    rise = tick.clock_level && !last_clk_eff;
    fall = !tick.clock_level && last_clk_eff;

    clk_pass_d = clk_pass_q;
    pls_pass_d = pls_pass_q;
    in_burst_d = in_burst_q;

    if (rise) begin
      clk_pass_d = tick.rand_clock <= tick.clock_chance;
      pls_pass_d = clk_pass_d && (tick.rand_pulse <= tick.pulse_chance);
      if (start_pend_d || in_burst_q) begin
        if (clk_pass_d && (CmpW'(cnt_d) >= pulses)) begin
          cnt_d      = '0;
          in_burst_d = 1'b0;
        end else begin
          if (clk_pass_d) begin
            cnt_d = cnt_d + CntW'(1);
          end
          in_burst_d = 1'b1;
        end
        start_pend_d = 1'b0;
      end
    end

    if (fall && (CmpW'(cnt_d) >= pulses)) begin
      in_burst_d = 1'b0;
    end

    // start and end trigger pulses
    start_left_d = start_left_q;
    start_out    = 1'b0;
    if (!in_burst_q && in_burst_d) begin
      if (pulse_ticks_q > start_left_q) begin
        start_left_d = pulse_ticks_q;
      end
    end else if (start_left_q != '0) begin
      start_left_d = start_left_q - TICKS_W'(1);
      start_out    = 1'b1;
    end

    end_left_d = end_left_q;
    end_out    = 1'b0;
    if (in_burst_q && !in_burst_d) begin
      if (pulse_ticks_q > end_left_q) begin
        end_left_d = pulse_ticks_q;
      end
    end else if (end_left_q != '0) begin
      end_left_d = end_left_q - TICKS_W'(1);
      end_out    = 1'b1;
    end

    out_d               = '0;
    out_d.pulse_out     = in_burst_d && pls_pass_d && tick.clock_level;
    out_d.burst_gate    = in_burst_d;
    out_d.start_trigger = start_out;
    out_d.end_trigger   = end_out;
    out_d.clock_out     = (bypass_q || clk_pass_d) && tick.clock_level;

    if (accept) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q        <= '0;
      in_burst_q   <= 1'b0;
      start_pend_q <= 1'b0;
      clk_pass_q   <= 1'b1;
      pls_pass_q   <= 1'b1;
      last_clk_q   <= 1'b0;
      last_trig_q  <= 1'b0;
      start_left_q <= '0;
      end_left_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (accept) begin
        cnt_q        <= cnt_d;
        in_burst_q   <= in_burst_d;
        start_pend_q <= start_pend_d;
        clk_pass_q   <= clk_pass_d;
        pls_pass_q   <= pls_pass_d;
        last_clk_q   <= tick.clock_level;
        last_trig_q  <= tick.trigger_level;
        start_left_q <= start_left_d;
        end_left_q   <= end_left_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= out_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/cbg_checker.sv
// port-level checks for the clocked burst generator
// depends on cbg_pkg; bound to clocked_burst_generator below
`default_nettype none

module cbg_checker (
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      s_axis_tvalid,
  input wire logic                      s_axis_tready,
  input wire logic                      m_axis_tvalid,
  input wire logic                      m_axis_tready,
  input wire logic [cbg_pkg::OUT_W-1:0] m_axis_tdata
);
  import cbg_pkg::*;

  cbg_out_t res;
  assign res = cbg_out_t'(m_axis_tdata);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // input only stalls behind a stalled result
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled with output free");

  // every input transaction yields a result in the next cycle
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
    else $error("result missing after input transaction");

  // a gated pulse needs the burst gate and a passed clock
  a_pulse_gate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res.pulse_out |-> res.burst_gate && res.clock_out)
    else $error("pulse outside burst or clock");

endmodule

bind clocked_burst_generator cbg_checker u_cbg_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

>>> tb/clocked_burst_generator_checker.sv
// checker for the clocked burst generator: follows register writes and tick
// transactions, predicts each result and compares it; depends on cbg_pkg
module clocked_burst_generator_checker #(
  parameter int MAX_BURST = 128
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [cbg_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [cbg_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                           s_tvalid_i,
  input  logic                           s_tready_i,
  input  cbg_pkg::cbg_in_t               s_tdata_i,
  input  logic                           m_tvalid_i,
  input  logic                           m_tready_i,
  input  cbg_pkg::cbg_out_t              m_tdata_i,
  output int                             errors_o,
  output int                             pending_o
);
  import cbg_pkg::*;

  // register copies
  logic               retrig_on;
  logic               bypass_on;
  logic [TICKS_W-1:0] trig_ticks;

  // burst state
  logic signed [11:0] pulse_count;
  logic               bursting;
  logic               was_bursting;
  logic               armed;
  logic               clk_ok;
  logic               pulse_ok;
  logic               prev_clk;
  logic               prev_trig;
  logic [TICKS_W-1:0] start_left;
  logic [TICKS_W-1:0] end_left;

  cbg_out_t tick_results_q [$];
  int       mismatches;
  int       outstanding;

  string field_name [OUT_FIELDS_W] = '{
    "pulse_out", "burst_gate", "start_trigger", "end_trigger", "clock_out"
  };

  assign errors_o  = mismatches;
  assign pending_o = outstanding;

  function automatic cbg_out_t burst_tick(input cbg_in_t t);
    logic signed [11:0] need;
    logic               rise;
    logic               fall;
    logic               ended;
    cbg_out_t           r;
    r    = '0;
    need = $signed({4'b0, t.burst_length});
    if (need < 1) need = 1;
    if (need > MAX_BURST) need = MAX_BURST;

    // a trigger edge arms the burst and forces a clock edge if the clock is high
    if (t.trigger_level && !prev_trig && (!bursting || retrig_on)) begin
      prev_clk    = 1'b0;
      armed       = 1'b1;
      pulse_count = -1;
    end
    prev_trig = t.trigger_level;

    rise     = t.clock_level && !prev_clk;
    fall     = !t.clock_level && prev_clk;
    prev_clk = t.clock_level;

    if (rise) begin
      clk_ok   = t.rand_clock <= t.clock_chance;
      pulse_ok = clk_ok && (t.rand_pulse <= t.pulse_chance);
      if (armed || bursting) begin
        ended = 1'b0;
        if (clk_ok) begin
          pulse_count = pulse_count + 1;
          ended       = pulse_count >= need;
        end
        if (ended) begin
          pulse_count = -1;
          bursting    = 1'b0;
        end else begin
          bursting = 1'b1;
        end
        armed = 1'b0;
      end
    end
    if (fall && pulse_count + 1 >= need) bursting = 1'b0;

    // the output is low on the tick that loads its counter
    if (!was_bursting && bursting) begin
      if (trig_ticks > start_left) start_left = trig_ticks;
    end else if (start_left != 0) begin
      r.start_trigger = 1'b1;
      start_left      = start_left - 1'b1;
    end
    if (was_bursting && !bursting) begin
      if (trig_ticks > end_left) end_left = trig_ticks;
    end else if (end_left != 0) begin
      r.end_trigger = 1'b1;
      end_left      = end_left - 1'b1;
    end

    r.pulse_out  = bursting && pulse_ok && t.clock_level;
    r.burst_gate = bursting;
    r.clock_out  = (bypass_on || clk_ok) && t.clock_level;
    was_bursting = bursting;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    cbg_out_t           want;
    logic [OUT_W-1:0]   want_bits;
    logic [OUT_W-1:0]   got_bits;
    if (!rst_ni) begin
      retrig_on    = 1'b0;
      bypass_on    = 1'b0;
      trig_ticks   = PULSE_TICKS_RST;
      pulse_count  = -1;
      bursting     = 1'b0;
      was_bursting = 1'b0;
      armed        = 1'b0;
      clk_ok       = 1'b1;
      pulse_ok     = 1'b1;
      prev_clk     = 1'b0;
      prev_trig    = 1'b0;
      start_left   = '0;
      end_left     = '0;
      tick_results_q.delete();
      mismatches   = 0;
      outstanding  = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_RETRIGGER:   retrig_on  = cfg_wdata_i[0];
          REG_BYPASS:      bypass_on  = cfg_wdata_i[0];
          REG_PULSE_TICKS: trig_ticks = cfg_wdata_i[TICKS_W-1:0];
          default: ;
        endcase
      end
      if (s_tvalid_i && s_tready_i) tick_results_q.push_back(burst_tick(s_tdata_i));
      if (m_tvalid_i && m_tready_i) begin
        if (tick_results_q.size() == 0) begin
          $error("result transaction with no tick waiting: %h", m_tdata_i);
          mismatches++;
        end else begin
          want      = tick_results_q.pop_front();
          want_bits = want;
          got_bits  = m_tdata_i;
          for (int i = 0; i < OUT_FIELDS_W; i++) begin
            if (got_bits[i] !== want_bits[i]) begin
              $error("%s: expected %0b, got %0b", field_name[i], want_bits[i], got_bits[i]);
              mismatches++;
            end
          end
          if (m_tdata_i.pad !== '0) begin
            $error("pad: expected 0, got %h", m_tdata_i.pad);
            mismatches++;
          end
        end
      end
      outstanding = tick_results_q.size();
    end
  end

endmodule

>>> tb/clocked_burst_generator_tb.sv
// testbench top for the clocked burst generator: clock, reset, register
// writes and tick stimulus; depends on cbg_pkg and the checker module
module clocked_burst_generator_tb;
  import cbg_pkg::*;

  localparam int MAX_BURST    = 128;
  localparam int PHASES       = 6;
  localparam int RANDOM_TICKS = 1250;
  localparam int HOLD_CYCLES  = 150;
  localparam int QUIET_LIMIT  = 5000;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

  typedef struct packed {
    logic               retrig;
    logic               bypass;
    logic [TICKS_W-1:0] ticks;
  } setting_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  cbg_in_t               s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_W-1:0]      m_axis_tdata;

  int errors;
  int pending;
  int ticks_in;
  int results_out;
  int quiet_cycles;

  bit gap_en   = 1'b1;
  bit stall_en = 1'b1;
  bit hold_req = 1'b0;

  // free-running clock waveform and trigger shaping for the random ticks
  bit          wave_lvl;
  int          wave_left;
  int          trig_left;
  logic [7:0]  length_now = 8'd4;
  setting_t    plan [PHASES];

  clocked_burst_generator #(
    .MAX_BURST(MAX_BURST)
  ) u_top (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  clocked_burst_generator_checker #(
    .MAX_BURST(MAX_BURST)
  ) u_checker (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_i (s_axis_tready),
    .s_tdata_i  (s_axis_tdata),
    .m_tvalid_i (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_i  (m_axis_tdata),
    .errors_o   (errors),
    .pending_o  (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog: ends the run when no transaction moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if (s_axis_tvalid && s_axis_tready) ticks_in++;
      if (m_axis_tvalid && m_axis_tready) results_out++;
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    @(posedge rst_n);
    forever begin
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (stall_en && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  task automatic send_tick(input cbg_in_t t);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= t;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (gap_en && $urandom_range(0, 9) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  task automatic drive(input bit c, input bit tr, input logic [7:0] len,
                       input logic [15:0] cc, input logic [15:0] pc,
                       input logic [15:0] rc, input logic [15:0] rp);
    cbg_in_t t;
    t               = '0;
    t.clock_level   = c;
    t.trigger_level = tr;
    t.burst_length  = len;
    t.clock_chance  = cc;
    t.pulse_chance  = pc;
    t.rand_clock    = rc;
    t.rand_pulse    = rp;
    send_tick(t);
  endtask

  // stop offering ticks and wait until every result has been checked
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic cbg_in_t random_tick();
    cbg_in_t t;
    int      pick;
    t = '0;
    if (wave_left == 0) begin
      wave_lvl  = !wave_lvl;
      wave_left = $urandom_range(1, 4);
    end
    wave_left--;
    if (trig_left == 0 && $urandom_range(0, 24) == 0) begin
      trig_left  = $urandom_range(1, 6);
      length_now = ($urandom_range(0, 15) == 0) ? 8'($urandom_range(0, 255))
                                                : 8'($urandom_range(1, 8));
    end
    t.clock_level   = wave_lvl;
    t.trigger_level = trig_left != 0;
    if (trig_left != 0) trig_left--;
    // occasional glitches on the levels and the length
    if ($urandom_range(0, 31) == 0) t.clock_level = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 63) == 0) t.trigger_level = 1'($urandom_range(0, 1));
    t.burst_length = ($urandom_range(0, 31) == 0) ? 8'($urandom_range(0, 255)) : length_now;
    pick = $urandom_range(0, 3);
    if (pick == 0) begin
      t.clock_chance = 16'($urandom_range(0, 65535));
      t.pulse_chance = 16'($urandom_range(0, 65535));
    end else if (pick == 1) begin
      t.clock_chance = 16'hFFFF;
      t.pulse_chance = 16'hFFFF;
    end else begin
      t.clock_chance = 16'($urandom_range(49152, 65535));
      t.pulse_chance = 16'($urandom_range(32768, 65535));
    end
    t.rand_clock = 16'($urandom_range(0, 65535));
    t.rand_pulse = 16'($urandom_range(0, 65535));
    return t;
  endfunction

  initial begin
    plan[0] = '{1'b1, 1'b1, 16'd1};
    plan[1] = '{1'b0, 1'b1, 16'hFFFF};
    plan[2] = '{1'b1, 1'b0, 16'd0};
    plan[3] = '{1'b1, 1'b1, 16'd3};
    plan[4] = '{1'b0, 1'b0, 16'd48};
    plan[5] = '{1'b1, 1'b0, 16'd6};

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed ticks under the reset register values
    drive(0, 0, 8'd1,   16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000);
    drive(1, 0, 8'd1,   16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000); // clock test fails
    drive(0, 0, 8'd1,   16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000);
    drive(1, 0, 8'd0,   16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    drive(1, 1, 8'd0,   16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF); // trigger on a high clock
    drive(0, 1, 8'd0,   16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF); // zero length ends at fall
    drive(1, 0, 8'd255, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000);
    drive(0, 0, 8'd255, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000);
    drive(0, 1, 8'd255, 16'hFFFF, 16'h0000, 16'h1234, 16'h0001); // armed on a low clock
    drive(1, 1, 8'd255, 16'h1234, 16'h0000, 16'h1234, 16'h0001); // equal passes, pulse fails
    drive(0, 0, 8'd255, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000);
    drive(1, 0, 8'd255, 16'h0000, 16'hFFFF, 16'h0001, 16'h0000); // failed clock keeps count
    drive(0, 1, 8'd255, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000); // retrigger refused
    drive(1, 1, 8'd3,   16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000);
    drive(0, 0, 8'd3,   16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000);
    drive(1, 0, 8'd3,   16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000);
    drive(0, 0, 8'd3,   16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000); // ends on falling clock
    drive(1, 0, 8'd2,   16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000);
    drive(0, 1, 8'd2,   16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000);
    drive(1, 1, 8'd2,   16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000);
    drive(0, 0, 8'd2,   16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000);
    drive(1, 0, 8'd1,   16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000); // count reaches length on rise
    drive(0, 0, 8'd1,   16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000);

    for (int p = 0; p < PHASES; p++) begin
      drain();
      // upper bits of the one-bit registers carry noise
      cfg_write(REG_RETRIGGER, {15'($urandom), plan[p].retrig});
      cfg_write(REG_BYPASS, {15'($urandom), plan[p].bypass});
      cfg_write(REG_PULSE_TICKS, plan[p].ticks);
      if (p == 2) cfg_write(REG_UNMAPPED, 16'hFFFF);
      if (p == PHASES - 1) begin
        gap_en   = 1'b0;
        stall_en = 1'b0;
      end
      for (int n = 0; n < RANDOM_TICKS / PHASES; n++) begin
        if (p == 1 && n == 60) hold_req = 1'b1;
        send_tick(random_tick());
      end
    end

    drain();
    repeat (4) @(posedge clk);
    $display("ran %0d ticks over %0d register settings, %0d results compared",
             ticks_in, PHASES + 1, results_out);
    $display("covered retrigger on and off, clock bypass, pulse lengths 0 to 65535");
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
